@@ rtl/sgr_mouse_report_parser_core_defines.svh @@
// ----------------------------------------------------------------------------
// SGR mouse report parser assertion macros
// Shared property forms for the parser core, clocked on clk and disabled
// while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SGR_MOUSE_REPORT_PARSER_CORE_DEFINES_SVH
`define SGR_MOUSE_REPORT_PARSER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMRP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SMRP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/smrp_pkg.sv @@
// ----------------------------------------------------------------------------
// SGR mouse report parser package
// Event codes and the decoded event record shared by the parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package smrp_pkg;

	localparam int OUT_COORD_W = 16;

	typedef enum logic [2:0] {
		KIND_UNKNOWN    = 3'd0,
		KIND_PRESS      = 3'd1,
		KIND_RELEASE    = 3'd2,
		KIND_MOTION     = 3'd3,
		KIND_WHEEL_UP   = 3'd4,
		KIND_WHEEL_DOWN = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		BTN_NONE   = 3'd0,
		BTN_LEFT   = 3'd1,
		BTN_MIDDLE = 3'd2,
		BTN_RIGHT  = 3'd3,
		BTN_OTHER  = 3'd4
	} button_t;

	typedef struct packed {
		kind_t                  kind;
		button_t                button;
		logic [OUT_COORD_W-1:0] column;
		logic [OUT_COORD_W-1:0] row;
		logic [2:0]             mods;
	} event_t;

endpackage

`default_nettype wire

@@ rtl/smrp_parser.sv @@
// ----------------------------------------------------------------------------
// SGR mouse report parser state machine
// Matches the report byte by byte, accumulates the decimal fields and
// decodes the event that the final byte of a buffer completes.
// ----------------------------------------------------------------------------
`default_nettype none

module smrp_parser #(
	parameter int MAX_DIGITS = 15,
	parameter int COORD_BITS = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          take,
	input  wire logic [7:0]    byte_in,
	input  wire logic          last_byte,
	output smrp_pkg::event_t   evt
);

	localparam int CNT_W = 4;
	localparam int MAC_W = COORD_BITS + 4;
	localparam logic [CNT_W-1:0] MaxDigits = CNT_W'(MAX_DIGITS);

	localparam logic [7:0] ChEsc     = 8'h1B;
	localparam logic [7:0] ChBracket = 8'h5B;
	localparam logic [7:0] ChLt      = 8'h3C;
	localparam logic [7:0] ChSemi    = 8'h3B;
	localparam logic [7:0] ChPress   = 8'h4D;
	localparam logic [7:0] ChRelease = 8'h6D;
	localparam logic [7:0] ChZero    = 8'h30;
	localparam logic [7:0] ChNine    = 8'h39;

	typedef enum logic [7:0] {
		PH_ESC     = 8'b0000_0001,
		PH_BRACKET = 8'b0000_0010,
		PH_LT      = 8'b0000_0100,
		PH_CODE    = 8'b0000_1000,
		PH_COL     = 8'b0001_0000,
		PH_ROW     = 8'b0010_0000,
		PH_DONE    = 8'b0100_0000,
		PH_BAD     = 8'b1000_0000
	} phase_t;

	phase_t                ph_q, ph_d;
	logic [6:0]            code_q, code_d;
	logic [COORD_BITS-1:0] col_q, col_d;
	logic [COORD_BITS-1:0] row_q, row_d;
	logic [CNT_W-1:0]      cnt_q, cnt_d;
	logic                  rel_q, rel_d;

	logic                  is_digit;
	logic [3:0]            dval;
	logic [9:0]            code_mac;
	logic [COORD_BITS-1:0] acc_in;
	logic [MAC_W-1:0]      acc_mac;
	logic [COORD_BITS-1:0] acc_sat;
	logic [1:0]            bb;

	assign is_digit = byte_in inside {[ChZero:ChNine]};
	assign dval     = byte_in[3:0];
	assign code_mac = 10'({code_q, 3'b000}) + 10'({code_q, 1'b0}) + 10'(dval);
	assign acc_in   = (ph_q == PH_COL) ? col_q : row_q;
	assign acc_mac  = MAC_W'({acc_in, 3'b000}) + MAC_W'({acc_in, 1'b0}) + MAC_W'(dval);
	assign acc_sat  = (acc_mac[MAC_W-1:COORD_BITS] != '0) ? {COORD_BITS{1'b1}}
	                                                      : acc_mac[COORD_BITS-1:0];

	always_comb begin
		ph_d   = ph_q;
		code_d = code_q;
		col_d  = col_q;
		row_d  = row_q;
		cnt_d  = cnt_q;
		rel_d  = rel_q;
		case (ph_q)
			PH_ESC: begin
				ph_d = (byte_in == ChEsc) ? PH_BRACKET : PH_BAD;
			end
			PH_BRACKET: begin
				ph_d = (byte_in == ChBracket) ? PH_LT : PH_BAD;
			end
			PH_LT: begin
				ph_d  = (byte_in == ChLt) ? PH_CODE : PH_BAD;
				cnt_d = '0;
			end
			PH_CODE, PH_COL, PH_ROW: begin
				if (is_digit) begin
					if (cnt_q >= MaxDigits) begin
						ph_d = PH_BAD;
					end else begin
						cnt_d = cnt_q + 1'b1;
						if (ph_q == PH_CODE) begin
							code_d = code_mac[6:0];
						end else if (ph_q == PH_COL) begin
							col_d = acc_sat;
						end else begin
							row_d = acc_sat;
						end
					end
				end else if (ph_q != PH_ROW && byte_in == ChSemi) begin
					ph_d  = (ph_q == PH_CODE) ? PH_COL : PH_ROW;
					cnt_d = '0;
				end else if (ph_q == PH_ROW && byte_in inside {ChPress, ChRelease}) begin
					rel_d = (byte_in == ChRelease);
					ph_d  = PH_DONE;
				end else begin
					ph_d = PH_BAD;
				end
			end
			default: begin
			end
		endcase
	end

	assign bb = code_d[1:0];

	always_comb begin
		evt = '{kind: smrp_pkg::KIND_UNKNOWN, button: smrp_pkg::BTN_NONE,
		        column: '0, row: '0, mods: '0};
		if (ph_d == PH_DONE) begin
			evt.column = smrp_pkg::OUT_COORD_W'(col_d);
			evt.row    = smrp_pkg::OUT_COORD_W'(row_d);
			evt.mods   = code_d[4:2];
			if (code_d[6]) begin
				evt.kind = (bb == 2'd0) ? smrp_pkg::KIND_WHEEL_UP : smrp_pkg::KIND_WHEEL_DOWN;
			end else begin
				evt.kind = code_d[5] ? smrp_pkg::KIND_MOTION
				         : (rel_d ? smrp_pkg::KIND_RELEASE : smrp_pkg::KIND_PRESS);
				case (bb)
					2'd0:    evt.button = smrp_pkg::BTN_LEFT;
					2'd1:    evt.button = smrp_pkg::BTN_MIDDLE;
					2'd2:    evt.button = smrp_pkg::BTN_RIGHT;
					default: evt.button = code_d[5] ? smrp_pkg::BTN_NONE
					                                : smrp_pkg::BTN_OTHER;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_ESC;
			code_q <= '0;
			col_q  <= '0;
			row_q  <= '0;
			cnt_q  <= '0;
			rel_q  <= 1'b0;
		end else if (take && last_byte) begin
			ph_q   <= PH_ESC;
			code_q <= '0;
			col_q  <= '0;
			row_q  <= '0;
			cnt_q  <= '0;
			rel_q  <= 1'b0;
		end else if (take) begin
			ph_q   <= ph_d;
			code_q <= code_d;
			col_q  <= col_d;
			row_q  <= row_d;
			cnt_q  <= cnt_d;
			rel_q  <= rel_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/sgr_mouse_report_parser_core.sv @@
// ----------------------------------------------------------------------------
// SGR mouse report parser core: one byte per cycle, in_stall low while a slot is free.
// The last byte's event is registered in the output slot, or in the skid slot if that slot is held.
// Two result slots: input stalls only while two events wait for the consumer.
// Reset clears the parser to expect an escape byte and empties both slots.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sgr_mouse_report_parser_core_defines.svh"

module sgr_mouse_report_parser_core #(
	parameter int MAX_DIGITS = 15,
	parameter int COORD_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  byte_in,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       event_kind,
	output logic [2:0]       button_id,
	output logic [15:0]      column,
	output logic [15:0]      row,
	output logic [2:0]       modifier_bits
);

	smrp_pkg::event_t res;
	smrp_pkg::event_t out_q;
	smrp_pkg::event_t skid_q;
	logic             out_valid_q;
	logic             skid_valid_q;
	logic             take;
	logic             res_valid;
	logic             out_take;

	assign in_stall  = skid_valid_q;
	assign take      = in_valid && !in_stall;
	assign res_valid = take && last_byte;
	assign out_take  = out_valid_q && !out_stall;

	smrp_parser #(
		.MAX_DIGITS (MAX_DIGITS),
		.COORD_BITS (COORD_BITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.byte_in   (byte_in),
		.last_byte (last_byte),
		.evt       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || out_take) begin
			out_valid_q <= res_valid;
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (!out_valid_q || out_take) begin
			out_q <= res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_kind    = out_q.kind;
	assign button_id     = out_q.button;
	assign column        = out_q.column;
	assign row           = out_q.row;
	assign modifier_bits = out_q.mods;

	`SMRP_ASSERT_SAME(a_skid_needs_out, skid_valid_q, out_valid_q, "Skid slot full while output slot empty.")
	`SMRP_ASSERT_NEXT(a_stalled_event_kept, res_valid && out_valid_q && out_stall, skid_valid_q, "Event lost behind a stalled output.")
	`SMRP_ASSERT_NEXT(a_skid_drains, skid_valid_q && !out_stall, out_valid_q && !skid_valid_q, "Skid slot did not move to the output.")

endmodule

`default_nettype wire

@@ verif/sgr_mouse_report_parser_core_checker.sv @@
// ----------------------------------------------------------------------------
// SGR mouse report parser checker
// Watches both channels of the parser core and predicts the decoded event for
// every request that carries a buffer's last byte. Each event taken from the
// core is compared with the oldest prediction. The failure count and the
// number of events still awaited are handed to the testbench top.
// ----------------------------------------------------------------------------
`default_nettype none

module sgr_mouse_report_parser_core_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [7:0]  byte_in,
	input  wire logic        last_byte,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [2:0]  event_kind,
	input  wire logic [2:0]  button_id,
	input  wire logic [15:0] column,
	input  wire logic [15:0] row,
	input  wire logic [2:0]  modifier_bits,
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          MAX_DIGITS   = 15;
	localparam int unsigned COORD_MAX    = (1 << smrp_pkg::OUT_COORD_W) - 1;
	localparam logic [7:0]  ESC_BYTE     = 8'h1B;
	localparam logic [7:0]  BRACKET_BYTE = 8'h5B;
	localparam logic [7:0]  LT_BYTE      = 8'h3C;
	localparam logic [7:0]  SEMI_BYTE    = 8'h3B;
	localparam logic [7:0]  PRESS_BYTE   = 8'h4D;
	localparam logic [7:0]  RELEASE_BYTE = 8'h6D;
	localparam logic [7:0]  DIGIT_LO     = 8'h30;
	localparam logic [7:0]  DIGIT_HI     = 8'h39;

	typedef enum logic [2:0] {
		WAIT_ESC,
		WAIT_BRACKET,
		WAIT_LT,
		IN_CODE,
		IN_COLUMN,
		IN_ROW,
		TERMINATED,
		REJECTED
	} phase_t;

	phase_t            phase;
	logic [6:0]        code_bits;
	logic [15:0]       col_acc;
	logic [15:0]       row_acc;
	int unsigned       digits;
	logic              release_term;
	smrp_pkg::event_t  decoded_q[$];
	int                errors = 0;

	function automatic logic [15:0] saturating_mac(input logic [15:0] acc, input logic [3:0] d);
		int unsigned n;
		n = 32'(acc) * 10 + 32'(d);
		return (n > COORD_MAX) ? 16'(COORD_MAX) : n[15:0];
	endfunction

	task automatic clear_parser();
		phase = WAIT_ESC;
		code_bits = '0;
		col_acc = '0;
		row_acc = '0;
		digits = 0;
		release_term = 1'b0;
	endtask

	task automatic advance(input logic [7:0] b);
		logic       is_digit;
		logic [3:0] d;
		is_digit = (b >= DIGIT_LO) && (b <= DIGIT_HI);
		d = 4'(b - DIGIT_LO);
		case (phase)
			WAIT_ESC: begin
				phase = (b == ESC_BYTE) ? WAIT_BRACKET : REJECTED;
			end
			WAIT_BRACKET: begin
				phase = (b == BRACKET_BYTE) ? WAIT_LT : REJECTED;
			end
			WAIT_LT: begin
				phase = (b == LT_BYTE) ? IN_CODE : REJECTED;
				digits = 0;
			end
			IN_CODE, IN_COLUMN, IN_ROW: begin
				if (is_digit) begin
					if (digits >= MAX_DIGITS) begin
						phase = REJECTED;
					end else begin
						digits++;
						if (phase == IN_CODE) begin
							code_bits = 7'(32'(code_bits) * 10 + 32'(d));
						end else if (phase == IN_COLUMN) begin
							col_acc = saturating_mac(col_acc, d);
						end else begin
							row_acc = saturating_mac(row_acc, d);
						end
					end
				end else if (phase != IN_ROW && b == SEMI_BYTE) begin
					phase = (phase == IN_CODE) ? IN_COLUMN : IN_ROW;
					digits = 0;
				end else if (phase == IN_ROW && (b == PRESS_BYTE || b == RELEASE_BYTE)) begin
					release_term = (b == RELEASE_BYTE);
					phase = TERMINATED;
				end else begin
					phase = REJECTED;
				end
			end
			default: begin
			end
		endcase
	endtask

	function automatic smrp_pkg::event_t decode_report();
		smrp_pkg::event_t ev;
		logic [1:0]       bb;
		ev = '0;
		if (phase == TERMINATED) begin
			bb = code_bits[1:0];
			if (code_bits[6]) begin
				ev.kind = (bb == 2'd0) ? smrp_pkg::KIND_WHEEL_UP : smrp_pkg::KIND_WHEEL_DOWN;
				ev.button = smrp_pkg::BTN_NONE;
			end else if (code_bits[5]) begin
				ev.kind = smrp_pkg::KIND_MOTION;
				ev.button = (bb == 2'd3) ? smrp_pkg::BTN_NONE
				                         : smrp_pkg::button_t'(3'(bb) + 3'd1);
			end else begin
				ev.kind = release_term ? smrp_pkg::KIND_RELEASE : smrp_pkg::KIND_PRESS;
				ev.button = smrp_pkg::button_t'(3'(bb) + 3'd1);
			end
			ev.column = col_acc;
			ev.row = row_acc;
			ev.mods = code_bits[4:2];
		end
		return ev;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		smrp_pkg::event_t want;
		if (!arst_n) begin
			clear_parser();
			decoded_q.delete();
			pending <= 0;
			fail_count <= errors;
		end else begin
			if (out_valid && !out_stall) begin
				if (decoded_q.size() == 0) begin
					errors++;
					$display("%0t: event with none awaited: kind %0d button %0d col %0d row %0d mods %0d",
						$time, event_kind, button_id, column, row, modifier_bits);
				end else begin
					want = decoded_q.pop_front();
					if ({event_kind, button_id, column, row, modifier_bits} !== want) begin
						errors++;
						$display("%0t: expected kind %0d button %0d col %0d row %0d mods %0d",
							$time, want.kind, want.button, want.column, want.row, want.mods);
						$display("%0t: actual   kind %0d button %0d col %0d row %0d mods %0d",
							$time, event_kind, button_id, column, row, modifier_bits);
					end
				end
			end
			if (in_valid && !in_stall) begin
				advance(byte_in);
				if (last_byte) begin
					decoded_q.push_back(decode_report());
					clear_parser();
				end
			end
			pending <= decoded_q.size();
			fail_count <= errors;
		end
	end

endmodule

`default_nettype wire

@@ verif/sgr_mouse_report_parser_core_tb.sv @@
// ----------------------------------------------------------------------------
// SGR mouse report parser core testbench
// Sends directed reports covering every event kind, the modifier bits, empty
// and overlong fields, saturation, early ends, trailing bytes and broken
// prefixes, then random well-formed, damaged and noise buffers. The sender
// works in bursts and the receiver stalls in changing patterns. The checker
// beside the core predicts and compares every event.
// ----------------------------------------------------------------------------
`default_nettype none

module sgr_mouse_report_parser_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         BYTE_TARGET = 1800;
	localparam int         IDLE_LIMIT  = 2000;
	localparam logic [7:0] ESC_BYTE    = 8'h1B;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_TOGGLE
	} stall_mode_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  byte_in;
	logic        last_byte;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  event_kind;
	logic [2:0]  button_id;
	logic [15:0] column;
	logic [15:0] row;
	logic [2:0]  modifier_bits;
	int          fail_count;
	int          pending;

	logic [7:0]  report_bytes[$];
	int          burst_left = 0;
	int          bytes_sent = 0;
	int          idle_cycles = 0;
	stall_mode_t stall_mode;
	int          mode_left;

	sgr_mouse_report_parser_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.byte_in       (byte_in),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.event_kind    (event_kind),
		.button_id     (button_id),
		.column        (column),
		.row           (row),
		.modifier_bits (modifier_bits)
	);

	sgr_mouse_report_parser_core_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.byte_in       (byte_in),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.event_kind    (event_kind),
		.button_id     (button_id),
		.column        (column),
		.row           (row),
		.modifier_bits (modifier_bits),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_mode <= STALL_NONE;
			mode_left <= 0;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= stall_mode_t'($urandom_range(0, 3));
				mode_left <= $urandom_range(20, 300);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				STALL_NONE:  out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default:     out_stall <= ~out_stall;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic is_last);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
			if (gap > 0) begin
				if (in_valid) in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		byte_in <= b;
		last_byte <= is_last;
		do @(posedge clk); while (in_stall);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic send_report();
		foreach (report_bytes[i]) push_byte(report_bytes[i], i == report_bytes.size() - 1);
		report_bytes.delete();
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) report_bytes.push_back(s[i]);
	endtask

	task automatic add_prefix();
		report_bytes.push_back(ESC_BYTE);
		add_text("[<");
	endtask

	task automatic directed(input string body);
		add_prefix();
		add_text(body);
		send_report();
	endtask

	task automatic add_field(input bit is_code);
		int pick;
		pick = $urandom_range(0, 39);
		if (pick == 0) begin
		end else if (pick == 1) begin
			repeat (16) add_text($sformatf("%0d", $urandom_range(0, 9)));
		end else if (pick < 6) begin
			repeat ($urandom_range(6, 15)) add_text($sformatf("%0d", $urandom_range(0, 9)));
		end else if (is_code) begin
			add_text($sformatf("%0d", $urandom_range(0, 127)));
		end else if ($urandom_range(0, 9) == 0) begin
			add_text($sformatf("%0d", $urandom_range(0, 99999)));
		end else begin
			add_text($sformatf("%0d", $urandom_range(0, 300)));
		end
	endtask

	task automatic drain();
		if (in_valid) in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		int pick;
		int report_idx;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		byte_in <= '0;
		last_byte <= 1'b0;
		report_idx = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		directed("0;1;1M");
		directed("0;1;1m");
		directed("1;65535;65535M");
		directed("2;7;9m");
		directed("3;1;1M");
		directed("32;10;20M");
		directed("35;10;20M");
		directed("64;5;5M");
		directed("65;5;5m");
		directed("127;1;1M");
		directed("28;2;3M");
		directed(";;M");
		directed("0;999999999999999;999999999999999M");
		directed("999999999999999;1;1M");
		directed("0;1234567890123456;1M");
		directed("0;1;65536M");
		directed("0;1;1Mzz");
		directed("0;1;1;M");
		directed("0;1;1");
		directed("0;1M");
		add_text("[<0;1;1M");
		send_report();
		report_bytes.push_back(8'hFF);
		send_report();
		report_bytes.push_back(8'h00);
		send_report();
		report_bytes.push_back(ESC_BYTE);
		send_report();
		drain();

		while (bytes_sent < BYTE_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 20) begin
				repeat ($urandom_range(1, 6)) report_bytes.push_back(8'($urandom_range(0, 255)));
			end else begin
				add_prefix();
				add_field(1'b1);
				add_text(";");
				add_field(1'b0);
				add_text(";");
				add_field(1'b0);
				add_text($urandom_range(0, 1) ? "m" : "M");
				if ($urandom_range(0, 4) == 0) begin
					repeat ($urandom_range(1, 3)) report_bytes.push_back(8'($urandom_range(0, 255)));
				end
				pick = $urandom_range(0, 9);
				if (pick == 0) begin
					report_bytes[$urandom_range(0, report_bytes.size() - 1)] = 8'($urandom_range(0, 255));
				end else if (pick == 1) begin
					repeat ($urandom_range(1, report_bytes.size() - 1)) void'(report_bytes.pop_back());
				end
			end
			send_report();
			report_idx++;
			if (report_idx % 40 == 0) drain();
		end

		drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire
